// ===== hdl/ird_pkg.sv =====
// ----------------------------------------------------------------------------
// ird_pkg
// Shared codes and types of the input-restricted deque: operation codes,
// status codes and the per-cycle command of the cell row.
// ----------------------------------------------------------------------------
package ird_pkg;

    typedef logic [1:0]         func_t;
    typedef logic [1:0]         status_t;
    typedef logic signed [31:0] word_t;

    localparam func_t OP_INSERT    = 2'd0;
    localparam func_t OP_REM_FRONT = 2'd1;
    localparam func_t OP_REM_REAR  = 2'd2;
    localparam func_t OP_LIST      = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    typedef logic [1:0] cell_op_t;

    // hold: keep word; load: take input word if target; shift: take right
    // neighbor; rotate: take right neighbor, target cell takes the front word
    localparam cell_op_t CELL_HOLD   = 2'd0;
    localparam cell_op_t CELL_LOAD   = 2'd1;
    localparam cell_op_t CELL_SHIFT  = 2'd2;
    localparam cell_op_t CELL_ROTATE = 2'd3;

    typedef struct packed {
        cell_op_t op;
        word_t    value;
    } cell_cmd_t;

endpackage

// ===== hdl/ird_in_if.sv =====
// ----------------------------------------------------------------------------
// ird_in_if
// Request channel of the deque: operation code and word to insert.
// ----------------------------------------------------------------------------
interface ird_in_if;
    import ird_pkg::*;

    logic  valid;
    logic  ready;
    func_t func;
    word_t value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);

endinterface

// ===== hdl/ird_out_if.sv =====
// ----------------------------------------------------------------------------
// ird_out_if
// Result channel of the deque: status, returned word and last-result flag.
// ----------------------------------------------------------------------------
interface ird_out_if;
    import ird_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    word_t   data_out;
    logic    last;

    modport source (output valid, output status, output data_out, output last, input ready);
    modport sink   (input valid, input status, input data_out, input last, output ready);

endinterface

// ===== hdl/ird_cell.sv =====
// ----------------------------------------------------------------------------
// ird_cell
// One storage cell of the deque row. Holds one word and, on command, loads
// the input word, takes its right neighbor's word, or closes the rotation
// ring by taking the front word.
// ----------------------------------------------------------------------------
module ird_cell
    import ird_pkg::*;
#(
    parameter int IDX_W = 3,
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  cell_cmd_t        cmd,
    input  logic [IDX_W-1:0] tgt,
    input  word_t            right_word,
    input  word_t            front_word,
    output word_t            word
);

    word_t word_reg;
    word_t word_next;
    logic  is_tgt;

    assign is_tgt = (tgt == IDX_W'(INDEX));

    always_comb
    begin
        word_next = word_reg;
        case (cmd.op)
            CELL_HOLD:   word_next = word_reg;
            CELL_LOAD:   word_next = is_tgt ? cmd.value : word_reg;
            CELL_SHIFT:  word_next = right_word;
            CELL_ROTATE: word_next = is_tgt ? front_word : right_word;
            default:     word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== hdl/input_restricted_deque.sv =====
// ----------------------------------------------------------------------------
// input_restricted_deque
// Deque of DEPTH signed words, inserts at the rear, removals at either end,
// built as a row of cells with the front word in cell 0 between operations.
// ----------------------------------------------------------------------------
// Insert and remove-front are done when the request is taken. A list gives one
// result per stored word (one result per cycle while the result side takes
// them), with the words rotating through the cell row and ending in their old
// order. Remove-rear of the only word is done when the request is taken;
// otherwise the row first rotates until the rear word sits in cell 0, then it
// is popped. No new request is taken while a list or a rotation runs.
// Removals and lists on an empty deque give one empty status.
// ----------------------------------------------------------------------------
module input_restricted_deque
    import ird_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    ird_in_if.sink    in_ch,
    ird_out_if.source out_ch
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LIST = 2'd1;
    localparam logic [1:0] S_ROT  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    logic    ov_reg, ov_next;
    status_t status_reg, status_next;
    word_t   data_reg, data_next;
    logic    last_reg, last_next;

    cell_cmd_t        cmd;
    logic [IDX_W-1:0] tgt;
    word_t            words [DEPTH];

    logic             slot_free;
    logic             accept;
    logic             full;
    logic [OCC_W-1:0] occ_m1;
    logic [IDX_W-1:0] rear_idx;

    assign slot_free   = !ov_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && slot_free;
    assign accept      = in_ch.valid && in_ch.ready;
    assign full        = (occ_reg == OCC_W'(DEPTH));
    assign occ_m1      = occ_reg - OCC_W'(1);
    assign rear_idx    = IDX_W'(occ_m1);

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        cmd.op      = CELL_HOLD;
        cmd.value   = in_ch.value;
        tgt         = rear_idx;
        ov_next     = out_ch.ready ? 1'b0 : ov_reg;
        status_next = status_reg;
        data_next   = data_reg;
        last_next   = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ov_next     = 1'b1;
                    status_next = ST_OK;
                    data_next   = '0;
                    last_next   = 1'b1;
                    if (in_ch.func == OP_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.op   = CELL_LOAD;
                            tgt      = IDX_W'(occ_reg);
                            occ_next = occ_reg + OCC_W'(1);
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (in_ch.func == OP_REM_FRONT ||
                             (in_ch.func == OP_REM_REAR && occ_reg == OCC_W'(1)))
                    begin
                        data_next = words[0];
                        cmd.op    = CELL_SHIFT;
                        occ_next  = occ_m1;
                    end
                    else if (in_ch.func == OP_REM_REAR)
                    begin
                        ov_next    = 1'b0;
                        cnt_next   = rear_idx;
                        state_next = S_ROT;
                    end
                    else
                    begin
                        ov_next    = 1'b0;
                        cnt_next   = '0;
                        state_next = S_LIST;
                    end
                end
            end
            S_LIST:
            begin
                if (slot_free)
                begin
                    ov_next     = 1'b1;
                    status_next = ST_OK;
                    data_next   = words[0];
                    last_next   = (OCC_W'(cnt_reg) == occ_m1);
                    cmd.op      = CELL_ROTATE;
                    cnt_next    = cnt_reg + IDX_W'(1);
                    if (OCC_W'(cnt_reg) == occ_m1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ROT:
            begin
                if (cnt_reg != '0)
                begin
                    cmd.op   = CELL_ROTATE;
                    cnt_next = cnt_reg - IDX_W'(1);
                end
                else if (slot_free)
                begin
                    ov_next     = 1'b1;
                    status_next = ST_OK;
                    data_next   = words[0];
                    last_next   = 1'b1;
                    cmd.op      = CELL_SHIFT;
                    occ_next    = occ_m1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ird_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .tgt        (tgt),
            .right_word (words[(i + 1) % DEPTH]),
            .front_word (words[0]),
            .word       (words[i])
        );
    end

    assign out_ch.valid    = ov_reg;
    assign out_ch.status   = status_reg;
    assign out_ch.data_out = data_reg;
    assign out_ch.last     = last_reg;

endmodule

// ===== tb/sv/ird_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_result_checker
// Watches both channels of the input-restricted deque, keeps its own copy of
// the deque contents, works out the results every accepted request must give
// and compares each accepted result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module ird_result_checker
    import ird_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic clk,
    input  logic rst_n,
    ird_in_if    in_ch,
    ird_out_if   out_ch,
    output int   errors,
    output int   pending,
    output int   checked
);

    typedef struct packed {
        status_t status;
        word_t   data_out;
        logic    last;
    } deque_result_t;

    word_t         words [DEPTH];
    int unsigned   head;
    int unsigned   occupancy;
    deque_result_t due_q [$];
    deque_result_t oldest;
    int            fail_count  = 0;
    int            check_count = 0;
    int            due_count   = 0;

    assign errors  = fail_count;
    assign pending = due_count;
    assign checked = check_count;

    function automatic void push_due(status_t status, word_t data, logic last);
        deque_result_t r;
        r.status   = status;
        r.data_out = data;
        r.last     = last;
        due_q.push_back(r);
    endfunction

    function automatic void apply_request(func_t func, word_t value);
        word_t       w;
        int unsigned i;
        if (func == OP_INSERT) begin
            if (occupancy >= DEPTH) begin
                push_due(ST_FULL, '0, 1'b1);
            end
            else begin
                words[(head + occupancy) % DEPTH] = value;
                occupancy++;
                push_due(ST_OK, '0, 1'b1);
            end
        end
        else if (occupancy == 0) begin
            push_due(ST_EMPTY, '0, 1'b1);
        end
        else if (func == OP_REM_FRONT) begin
            w = words[head];
            occupancy--;
            if (occupancy != 0)
                head = (head + 1) % DEPTH;
            push_due(ST_OK, w, 1'b1);
        end
        else if (func == OP_REM_REAR) begin
            w = words[(head + occupancy - 1) % DEPTH];
            occupancy--;
            push_due(ST_OK, w, 1'b1);
        end
        else begin
            for (i = 0; i < occupancy; i++)
                push_due(ST_OK, words[(head + i) % DEPTH], (i + 1 == occupancy));
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            head      = 0;
            occupancy = 0;
            due_q.delete();
            due_count = 0;
        end
        else begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (due_q.size() == 0) begin
                    $error("unexpected result: status %0d, data_out %0d, last %0d",
                           out_ch.status, out_ch.data_out, out_ch.last);
                    fail_count++;
                end
                else begin
                    oldest = due_q.pop_front();
                    check_count++;
                    if (out_ch.status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d",
                               oldest.status, out_ch.status);
                        fail_count++;
                    end
                    if (out_ch.data_out !== oldest.data_out) begin
                        $error("data_out: expected %0d, actual %0d",
                               oldest.data_out, out_ch.data_out);
                        fail_count++;
                    end
                    if (out_ch.last !== oldest.last) begin
                        $error("last: expected %0d, actual %0d",
                               oldest.last, out_ch.last);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                apply_request(in_ch.func, in_ch.value);
            due_count = due_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_input_restricted_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_input_restricted_deque
// Drives requests into the input-restricted deque: a directed opening over
// empty and full stores, single-word removals and wrap of the ring, then
// random traffic with bursts of idling on both channels, one long result
// hold-off that backs the deque up, and a quiet closing stretch. The checker
// beside the deque predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_input_restricted_deque;
    import ird_pkg::*;

    localparam int DEPTH        = 8;
    localparam int RANDOM_ITEMS = 75;
    localparam int PRESS_FIRST  = 20;
    localparam int PRESS_LAST   = 35;
    localparam int CALM_FIRST   = 55;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 4 * DEPTH;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    logic hold_go   = 1'b0;
    logic hold_done = 1'b0;
    logic calm      = 1'b0;
    logic pressing  = 1'b0;
    int   errors;
    int   pending;
    int   checked;
    int   op_count [4] = '{0, 0, 0, 0};

    ird_in_if  in_ch ();
    ird_out_if out_ch ();

    input_restricted_deque #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    ird_result_checker #(
        .DEPTH (DEPTH)
    ) i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // result side: random stalls, one long hold-off, none at the end
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic offer(func_t func, word_t value);
        int gap;
        if (!calm && !pressing && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.func  <= func;
        in_ch.value <= value;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        op_count[func]++;
    endtask

    function automatic word_t pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'sh7fff_ffff;
        else if (r == 1)
            return 32'sh8000_0000;
        else if (r == 2)
            return '0;
        return $urandom;
    endfunction

    initial
    begin
        int    n;
        int    r;
        func_t func;

        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func  = OP_INSERT;
        in_ch.value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty store
        offer(OP_LIST, '0);
        offer(OP_REM_FRONT, '1);
        offer(OP_REM_REAR, '1);
        // only word taken from either end
        offer(OP_INSERT, 32'sh7fff_ffff);
        offer(OP_REM_FRONT, '0);
        offer(OP_INSERT, 32'sh8000_0000);
        offer(OP_REM_REAR, '0);
        // extremes, then front moves so the rear wraps while filling
        offer(OP_INSERT, 32'sh8000_0000);
        offer(OP_INSERT, '0);
        offer(OP_INSERT, -32'sd1);
        offer(OP_INSERT, 32'sh7fff_ffff);
        offer(OP_REM_REAR, '0);
        offer(OP_REM_FRONT, '0);
        for (n = 0; n < DEPTH - 2; n++)
            offer(OP_INSERT, $urandom);
        offer(OP_INSERT, 32'sh1234_5678);
        offer(OP_LIST, '0);
        offer(OP_REM_FRONT, '0);
        offer(OP_REM_REAR, '0);
        offer(OP_INSERT, -32'sd2);
        offer(OP_LIST, '0);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == PRESS_FIRST)
            begin
                pressing = 1'b1;
                hold_go  = 1'b1;
            end
            if (n == PRESS_LAST)
                pressing = 1'b0;
            if (n == CALM_FIRST)
                calm = 1'b1;
            r = $urandom_range(0, 99);
            if (pressing)
                func = (r < 75) ? OP_INSERT : OP_LIST;
            else if (r < 40)
                func = OP_INSERT;
            else if (r < 60)
                func = OP_REM_FRONT;
            else if (r < 80)
                func = OP_REM_REAR;
            else
                func = OP_LIST;
            offer(func, pick_word());
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("tb: %0d requests: %0d insert, %0d remove front, %0d remove rear, %0d list",
                 op_count[OP_INSERT] + op_count[OP_REM_FRONT] + op_count[OP_REM_REAR]
                 + op_count[OP_LIST], op_count[OP_INSERT], op_count[OP_REM_FRONT],
                 op_count[OP_REM_REAR], op_count[OP_LIST]);
        $display("tb: %0d results compared, one %0d-cycle result hold-off, %0d mismatches",
                 checked, HOLD_CYCLES, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
